FILE: hw/rtl/cxs_pkg.sv
// ============================================================================
// cxs_pkg - shared constants, types and tables for the xyY to sRGB converter
// Holds the fixed-point widths, the sRGB D65 matrix, the pipeline stage map
// and the transfer curve table that is built at elaboration.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cxs_pkg;

    // Transfer curve table size: N intervals, N+1 entries.
    localparam int GAMMA_TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(GAMMA_TABLE_ENTRIES + 1);

    // Datapath widths.
    localparam int D_W   = 34;   // matrix row dot product, signed
    localparam int S_W   = 48;   // dot product times luminance, signed
    localparam int E_W   = 44;   // divisor 256000000 * y
    localparam int REM_W = E_W + 1;
    localparam int Q_W   = 24;   // linear value, Q0.24
    localparam int P_W   = Q_W + IDX_W;
    localparam int T_W   = 32;   // curve table entry, signed
    localparam int W_W   = 58;   // interpolation sum, signed

    // Stage map of the pipeline.
    localparam int MAT_STAGES     = 2;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STAGES     = Q_W / DIV_BITS;
    localparam int ENC_STAGES     = 6;
    localparam int ST_DIV         = MAT_STAGES;
    localparam int ST_ENC         = ST_DIV + DIV_STAGES + 1;
    localparam int N_STAGES       = ST_ENC + ENC_STAGES;

    // Arithmetic constants.
    localparam logic [E_W-1:0] E_SCALE   = E_W'(256000000);
    localparam logic [Q_W-1:0] LIN_KNEE  = Q_W'(52526);
    localparam logic [26:0]    LIN_GAIN  = 27'd84671220;   // 1292 * 65535
    localparam logic [43:0]    LIN_ROUND = 44'd838860800;  // 50 * 2^24
    localparam logic [17:0]    RECIP_25  = 18'd167772;     // floor(2^22 / 25)
    localparam logic [46:0]    CRV_ROUND = 47'd524288000;  // 500 * 2^20
    localparam logic [24:0]    RECIP_125 = 25'd17179869;   // floor(2^31 / 125)
    localparam logic [15:0]    UNORM_MAX = 16'hFFFF;

    // sRGB D65 matrix, scaled by 10000. Columns multiply X, Y and Z.
    typedef logic signed [D_W-1:0] t_mat_row [3];
    typedef t_mat_row t_mat [3];
    localparam t_mat SRGB_MAT = '{
        '{ D_W'(32406), -D_W'(15372), -D_W'(4986) },
        '{-D_W'(9689),   D_W'(18758),  D_W'(415)  },
        '{ D_W'(557),   -D_W'(2040),   D_W'(10570)}
    };

    // Per channel flags that travel with the quotient.
    typedef struct packed {
        logic zero;   // black: y zero or linear value not above zero
        logic sat;    // linear value at or above one
    } t_chan_flags;

    // Curve table: T[i] = 1055 * floor(2^20 * (i/N)^(5/12)) - 55 * 2^20.
    typedef logic signed [T_W-1:0] t_curve_rom [0:GAMMA_TABLE_ENTRIES];

    function automatic t_curve_rom build_curve_rom();
        t_curve_rom rom;
        logic [319:0] rhs;
        logic [319:0] lhs;
        logic [20:0]  root;
        logic [20:0]  cand;
        for (int i = 0; i <= GAMMA_TABLE_ENTRIES; i++) begin
            rhs = 320'd1;
            for (int k = 0; k < 5; k++) begin
                rhs = rhs * 320'(i);
            end
            rhs = rhs << 240;
            root = '0;
            for (int b = 20; b >= 0; b--) begin
                cand = root | (21'd1 << b);
                if (cand <= 21'd1048576) begin
                    lhs = 320'd1;
                    for (int k = 0; k < 12; k++) begin
                        lhs = lhs * 320'(cand);
                    end
                    for (int k = 0; k < 5; k++) begin
                        lhs = lhs * 320'(GAMMA_TABLE_ENTRIES);
                    end
                    if (lhs <= rhs) begin
                        root = cand;
                    end
                end
            end
            rom[i] = T_W'(longint'(root) * 1055 - 57671680);
        end
        return rom;
    endfunction

    localparam t_curve_rom CURVE_ROM = build_curve_rom();

endpackage

`default_nettype wire

FILE: hw/rtl/cie_xyy_to_srgb.sv
// ============================================================================
// cie_xyy_to_srgb - CIE xyY to gamma encoded sRGB (D65) converter
// Converts chromaticity x, y and luminance Y to 16-bit unorm red, green and
// blue through the sRGB matrix and the sRGB transfer curve.
// ============================================================================
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------
//   input   | in        | i_valid / o_stall   | i_chroma_x, i_chroma_y, i_luminance
//   output  | out       | o_valid / i_stall   | o_red, o_green, o_blue
//
// One item enters per cycle when nothing stalls. The pipeline has N_STAGES
// stages: two matrix stages, one range check, twelve divider stages of two
// quotient bits each, and six curve stages.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and the block keeps taking items while a result waits.
// Reset is synchronous and active low; it empties the pipeline. Data
// registers are not reset. o_stall is high during reset.
//
`timescale 1ns / 1ps
`default_nettype none

module cie_xyy_to_srgb import cxs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_chroma_x,
    input  logic [15:0] i_chroma_y,
    input  logic [14:0] i_luminance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue
);

    localparam int CNT_W = $clog2(N_STAGES + 1);

    logic [N_STAGES-1:0]   r_vld;
    logic [N_STAGES-1:0]   n_vld;
    logic [N_STAGES-1:0]   w_en;
    logic signed [S_W-1:0] w_sum [3];
    logic [E_W-1:0]        w_den;
    logic                  w_yzero;
    logic [Q_W-1:0]        w_quot  [3];
    t_chan_flags           w_flags [3];
    logic [15:0]           w_value [3];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  w_in_acc;
    logic                  w_out_acc;

    // Stage enables: a stage loads when it is empty or its successor moves on.
    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < N_STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_en[0] || !i_rst_n;
    assign o_valid = r_vld[N_STAGES-1];

    cxs_matrix u_matrix (
        .i_clk       (i_clk),
        .i_en        (w_en[MAT_STAGES-1:0]),
        .i_chroma_x  (i_chroma_x),
        .i_chroma_y  (i_chroma_y),
        .i_luminance (i_luminance),
        .o_sum       (w_sum),
        .o_den       (w_den),
        .o_yzero     (w_yzero)
    );

    for (genvar c = 0; c < 3; c++) begin : g_chan
        cxs_divider u_divider (
            .i_clk   (i_clk),
            .i_en    (w_en[ST_DIV+DIV_STAGES:ST_DIV]),
            .i_sum   (w_sum[c]),
            .i_den   (w_den),
            .i_yzero (w_yzero),
            .o_quot  (w_quot[c]),
            .o_flags (w_flags[c])
        );

        cxs_encode u_encode (
            .i_clk   (i_clk),
            .i_en    (w_en[N_STAGES-1:ST_ENC]),
            .i_quot  (w_quot[c]),
            .i_flags (w_flags[c]),
            .o_value (w_value[c])
        );
    end

    assign o_red   = w_value[0];
    assign o_green = w_value[1];
    assign o_blue  = w_value[2];

    // Items in flight, tracked from the ports, for the checks below.
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (w_in_acc && !w_out_acc) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_in_acc && w_out_acc) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Every accepted item sits in exactly one stage until it is delivered.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_vld)))
        else $error("pipeline occupancy does not match accepted items");

    // The input is held off only when every stage is full and the output stalls.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while the pipeline has room");

    // A delivered item leaves the last stage unless a new one moves in behind it.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !r_vld[N_STAGES-2]) |=> !o_valid)
        else $error("result repeated after delivery");

endmodule

`default_nettype wire

FILE: hw/rtl/cxs_matrix.sv
// ============================================================================
// cxs_matrix - chromaticity to scaled linear RGB numerators
// Two stages: the matrix dot product on x, y, 1-x-y, then the product with
// luminance. Also forms the common divisor and the black flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cxs_matrix import cxs_pkg::*; (
    input  logic                  i_clk,
    input  logic [MAT_STAGES-1:0] i_en,
    input  logic [15:0]           i_chroma_x,
    input  logic [15:0]           i_chroma_y,
    input  logic [14:0]           i_luminance,
    output logic signed [S_W-1:0] o_sum [3],
    output logic [E_W-1:0]        o_den,
    output logic                  o_yzero
);

    logic signed [D_W-1:0] w_x;
    logic signed [D_W-1:0] w_y;
    logic signed [D_W-1:0] w_z;
    logic signed [D_W-1:0] n_dot [3];
    logic signed [D_W-1:0] r_dot [3];
    logic [E_W-1:0]        r_den_a;
    logic                  r_yzero_a;
    logic [14:0]           r_lum;
    logic signed [S_W-1:0] r_sum [3];
    logic [E_W-1:0]        r_den;
    logic                  r_yzero;

    assign w_x = D_W'($signed({1'b0, i_chroma_x}));
    assign w_y = D_W'($signed({1'b0, i_chroma_y}));
    assign w_z = D_W'(65536) - w_x - w_y;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_dot[c] = SRGB_MAT[c][0] * w_x + SRGB_MAT[c][1] * w_y + SRGB_MAT[c][2] * w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dot     <= n_dot;
            r_den_a   <= E_W'(i_chroma_y) * E_SCALE;
            r_yzero_a <= (i_chroma_y == 16'd0);
            r_lum     <= i_luminance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= S_W'(r_dot[c]) * S_W'($signed({1'b0, r_lum}));
            end
            r_den   <= r_den_a;
            r_yzero <= r_yzero_a;
        end
    end

    assign o_sum   = r_sum;
    assign o_den   = r_den;
    assign o_yzero = r_yzero;

endmodule

`default_nettype wire

FILE: hw/rtl/cxs_divider.sv
// ============================================================================
// cxs_divider - pipelined restoring divider for one channel
// A range check stage, then DIV_STAGES stages of DIV_BITS quotient bits each
// give the linear value as a Q0.24 fraction of the divisor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cxs_divider import cxs_pkg::*; (
    input  logic                  i_clk,
    input  logic [DIV_STAGES:0]   i_en,
    input  logic signed [S_W-1:0] i_sum,
    input  logic [E_W-1:0]        i_den,
    input  logic                  i_yzero,
    output logic [Q_W-1:0]        o_quot,
    output t_chan_flags           o_flags
);

    logic [REM_W-1:0] r_rem   [0:DIV_STAGES];
    logic [Q_W-1:0]   r_quot  [0:DIV_STAGES];
    logic [E_W-1:0]   r_den   [0:DIV_STAGES];
    t_chan_flags      r_flags [0:DIV_STAGES];
    t_chan_flags      n_flags;
    logic signed [S_W-1:0] w_den_s;

    assign w_den_s = S_W'($signed({1'b0, i_den}));

    // The sign bit is tested directly so that the check stays a signed one.
    always_comb begin
        n_flags.zero = i_yzero || i_sum[S_W-1] || (i_sum == '0);
        n_flags.sat  = !n_flags.zero && (i_sum >= w_den_s);
    end

    // Range check: only a numerator strictly between zero and the divisor is divided.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]   <= (n_flags.zero || n_flags.sat) ? '0 : REM_W'(i_sum[E_W-1:0]);
            r_quot[0]  <= '0;
            r_den[0]   <= i_den;
            r_flags[0] <= n_flags;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
        logic [REM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quot;

        always_comb begin
            n_rem  = r_rem[g];
            n_quot = r_quot[g];
            for (int b = 0; b < DIV_BITS; b++) begin
                n_rem  = {n_rem[REM_W-2:0], 1'b0};
                n_quot = {n_quot[Q_W-2:0], 1'b0};
                if (n_rem >= REM_W'(r_den[g])) begin
                    n_rem     = n_rem - REM_W'(r_den[g]);
                    n_quot[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_rem[g+1]   <= n_rem;
                r_quot[g+1]  <= n_quot;
                r_den[g+1]   <= r_den[g];
                r_flags[g+1] <= r_flags[g];
            end
        end
    end

    assign o_quot  = r_quot[DIV_STAGES];
    assign o_flags = r_flags[DIV_STAGES];

endmodule

`default_nettype wire

FILE: hw/rtl/cxs_encode.sv
// ============================================================================
// cxs_encode - sRGB transfer curve for one channel
// Linear segment at or below the knee, interpolated table above it, rounding to
// 16-bit unorm by reciprocal multiply with one correction step.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cxs_encode import cxs_pkg::*; (
    input  logic                  i_clk,
    input  logic [ENC_STAGES-1:0] i_en,
    input  logic [Q_W-1:0]        i_quot,
    input  t_chan_flags           i_flags,
    output logic [15:0]           o_value
);

    // Stage 1
    logic [P_W-1:0]   w_pos;
    logic [43:0]      r_lin_m;
    logic             r_lin_1;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_k1;
    logic [Q_W-1:0]   r_f_1;
    t_chan_flags      r_fl_1;
    // Stage 2
    logic [43:0]         w_lin_sum;
    logic [17:0]         w_lin_t;
    logic signed [T_W-1:0] r_tk;
    logic signed [T_W-1:0] r_tk1;
    logic [35:0]         r_lin_p;
    logic [17:0]         r_lin_t;
    logic                r_lin_2;
    logic [Q_W-1:0]      r_f_2;
    t_chan_flags         r_fl_2;
    // Stage 3
    logic [13:0]         w_lq;
    logic [17:0]         w_lrem;
    logic signed [W_W-1:0] r_pa;
    logic signed [W_W-1:0] r_pb;
    logic [15:0]         r_lin_o3;
    logic                r_lin_3;
    t_chan_flags         r_fl_3;
    // Stage 4
    logic signed [W_W-1:0] w_sum;
    logic [46:0]         w_num;
    logic [23:0]         r_t2;
    logic                r_wpos;
    logic [15:0]         r_lin_o4;
    logic                r_lin_4;
    t_chan_flags         r_fl_4;
    // Stage 5
    logic [48:0]         r_p2;
    logic [23:0]         r_t2_5;
    logic                r_wpos_5;
    logic [15:0]         r_lin_o5;
    logic                r_lin_5;
    t_chan_flags         r_fl_5;
    // Stage 6
    logic [17:0]         w_cq;
    logic [24:0]         w_crem;
    logic [17:0]         w_cout;
    logic [15:0]         n_value;
    logic [15:0]         r_value;

    assign w_pos = P_W'(i_quot) * P_W'(GAMMA_TABLE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lin_m <= 44'(i_quot[15:0]) * 44'(LIN_GAIN);
            r_lin_1 <= (i_quot <= LIN_KNEE);
            r_k     <= w_pos[P_W-1:Q_W];
            r_k1    <= w_pos[P_W-1:Q_W] + IDX_W'(1);
            r_f_1   <= w_pos[Q_W-1:0];
            r_fl_1  <= i_flags;
        end
    end

    assign w_lin_sum = r_lin_m + LIN_ROUND;
    assign w_lin_t   = w_lin_sum[43:26];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_tk    <= CURVE_ROM[r_k];
            r_tk1   <= CURVE_ROM[r_k1];
            r_lin_p <= 36'(w_lin_t) * 36'(RECIP_25);
            r_lin_t <= w_lin_t;
            r_lin_2 <= r_lin_1;
            r_f_2   <= r_f_1;
            r_fl_2  <= r_fl_1;
        end
    end

    assign w_lq   = r_lin_p[35:22];
    assign w_lrem = r_lin_t - 18'(w_lq) * 18'd25;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_pa     <= W_W'(r_tk) *
                        W_W'($signed({1'b0, (25'd16777216 - 25'(r_f_2))}));
            r_pb     <= W_W'(r_tk1) * W_W'($signed({1'b0, r_f_2}));
            r_lin_o3 <= 16'(w_lq) + ((w_lrem >= 18'd25) ? 16'd1 : 16'd0);
            r_lin_3  <= r_lin_2;
            r_fl_3   <= r_fl_2;
        end
    end

    assign w_sum = r_pa + r_pb;
    assign w_num = 47'(w_sum[53:24]) * 47'(UNORM_MAX) + CRV_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_t2     <= w_num[46:23];
            r_wpos   <= !w_sum[W_W-1] && (w_sum != '0);
            r_lin_o4 <= r_lin_o3;
            r_lin_4  <= r_lin_3;
            r_fl_4   <= r_fl_3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_p2     <= 49'(r_t2) * 49'(RECIP_125);
            r_t2_5   <= r_t2;
            r_wpos_5 <= r_wpos;
            r_lin_o5 <= r_lin_o4;
            r_lin_5  <= r_lin_4;
            r_fl_5   <= r_fl_4;
        end
    end

    assign w_cq   = r_p2[48:31];
    assign w_crem = 25'(r_t2_5) - 25'(w_cq) * 25'd125;
    assign w_cout = w_cq + ((w_crem >= 25'd125) ? 18'd1 : 18'd0);

    always_comb begin
        priority if (r_fl_5.zero) begin
            n_value = '0;
        end else if (r_fl_5.sat) begin
            n_value = UNORM_MAX;
        end else if (r_lin_5) begin
            n_value = r_lin_o5;
        end else if (!r_wpos_5) begin
            n_value = '0;
        end else if (w_cout > 18'(UNORM_MAX)) begin
            n_value = UNORM_MAX;
        end else begin
            n_value = w_cout[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: dv/cie_xyy_to_srgb_tb.sv
// ============================================================================
// cie_xyy_to_srgb_tb - self-checking testbench for the xyY to sRGB converter
// Drives colours through the valid/stall input channel, predicts every pixel
// with an exact integer model of the matrix and transfer curve, and compares
// each output item field by field under three idling patterns.
// ============================================================================
`timescale 1ns / 1ps

module cie_xyy_to_srgb_tb;
    import cxs_pkg::*;

    localparam int CURVE_N      = GAMMA_TABLE_ENTRIES;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 2 * N_STAGES + 8;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_chroma_x = '0;
    logic [15:0] i_chroma_y = '0;
    logic [14:0] i_luminance = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_red;
    logic [15:0] o_green;
    logic [15:0] o_blue;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     mismatch_count = 0;
    int     quiet_cycles = 0;
    t_pixel pixel_queue[$];
    longint gamma_lut [0:CURVE_N];

    cie_xyy_to_srgb dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_chroma_x  (i_chroma_x),
        .i_chroma_y  (i_chroma_y),
        .i_luminance (i_luminance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always #5 i_clk = ~i_clk;

    // Curve table: entry i holds 1055 * floor(2^20 * (i/N)^(5/12)) - 55 * 2^20.
    // The root is found by bisection on r^12 * N^5 <= i^5 * 2^240.
    task automatic fill_gamma_lut();
        logic [319:0] bound;
        logic [319:0] power;
        longint       lo;
        longint       hi;
        longint       mid;
        for (int i = 0; i <= CURVE_N; i++) begin
            bound = 320'd1;
            for (int k = 0; k < 5; k++) bound = bound * 320'(i);
            bound = bound << 240;
            lo = 0;
            hi = 1048576;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                power = 320'd1;
                for (int k = 0; k < 12; k++) power = power * 320'(mid);
                for (int k = 0; k < 5; k++) power = power * 320'(CURVE_N);
                if (power <= bound) lo = mid;
                else hi = mid - 1;
            end
            gamma_lut[i] = 1055 * lo - 55 * 1048576;
        end
    endtask

    function automatic logic [15:0] encode_gamma(longint s, longint e);
        logic [95:0] num;
        longint      q;
        longint      p;
        longint      k;
        longint      f;
        longint      w;
        longint      v;
        if (s <= 0) return 16'd0;
        if (s >= e) return 16'hFFFF;
        num = 96'(s) << 24;
        q = longint'(num / 96'(e));
        if (q <= 52526) return 16'((q * 1292 * 65535 + 50 * 16777216) / (100 * 16777216));
        p = q * CURVE_N;
        k = p >>> 24;
        f = p & 64'hFFFFFF;
        if (k >= CURVE_N) k = CURVE_N - 1;
        w = gamma_lut[k] * (16777216 - f) + gamma_lut[k + 1] * f;
        if (w <= 0) return 16'd0;
        v = ((w >>> 24) * 65535 + 500 * 1048576) / (1000 * 1048576);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic t_pixel predict_pixel(logic [15:0] cx, logic [15:0] cy,
                                             logic [14:0] lum);
        t_pixel px;
        longint nx;
        longint ny;
        longint nz;
        longint e;
        longint row [3][3];
        logic [15:0] ch [3];
        row = '{'{32406, -15372, -4986}, '{-9689, 18758, 415}, '{557, -2040, 10570}};
        if (cy == 0) return '0;
        nx = longint'(cx) * lum;
        ny = longint'(cy) * lum;
        nz = (65536 - longint'(cx) - longint'(cy)) * lum;
        e  = 256000000 * longint'(cy);
        for (int c = 0; c < 3; c++)
            ch[c] = encode_gamma(row[c][0] * nx + row[c][1] * ny + row[c][2] * nz, e);
        px.red = ch[0];
        px.green = ch[1];
        px.blue = ch[2];
        return px;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Sends one colour; valid stays high across back-to-back items.
    task automatic send_colour(logic [15:0] cx, logic [15:0] cy, logic [14:0] lum);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_chroma_x  <= cx;
        i_chroma_y  <= cy;
        i_luminance <= lum;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixel_queue.push_back(predict_pixel(cx, cy, lum));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Black, chromaticity corners, luminance extremes and both curve branches.
    task automatic test_directed();
        send_colour(16'd0, 16'd0, 15'd25600);          // y zero gives black
        send_colour(16'hFFFF, 16'd0, 15'h7FFF);
        send_colour(16'd20493, 16'd21569, 15'd25600);   // D65 white at 100
        send_colour(16'd20493, 16'd21569, 15'd0);       // zero luminance
        send_colour(16'd20493, 16'd21569, 15'h7FFF);    // above 100 saturates
        send_colour(16'd20493, 16'd21569, 15'd40);      // linear segment
        send_colour(16'd20493, 16'd21569, 15'd80);      // near the knee
        send_colour(16'd20493, 16'd21569, 15'd1);
        send_colour(16'hFFFF, 16'hFFFF, 15'd25600);     // x + y above one
        send_colour(16'd0, 16'hFFFF, 15'd25600);
        send_colour(16'hFFFF, 16'd1, 15'd1);
        send_colour(16'd0, 16'd1, 15'h7FFF);
        send_colour(16'd41943, 16'd21627, 15'd5400);    // red primary
        send_colour(16'd19661, 16'd39322, 15'd17900);   // green primary
        send_colour(16'd9830, 16'd3932, 15'd1800);      // blue primary
        send_colour(16'd1, 16'd1, 15'd1);
        send_colour(16'h8000, 16'h8000, 15'h4000);
        send_colour(16'h5555, 16'h2AAA, 15'h2AAA);
        send_colour(16'h2AAA, 16'h5555, 15'h5555);
        end_burst();
    endtask

    // Mostly colours from a box of chromaticities, plus low luminance, full-range noise,
    // tiny y and luminance above the nominal range.
    task automatic test_random_stream(int count);
        logic [15:0] cx;
        logic [15:0] cy;
        logic [14:0] lum;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            cx = 16'($urandom_range(45000, 6000));
            cy = 16'($urandom_range(46000, 3000));
            lum = 15'($urandom_range(25600));
            if (pick < 15) lum = 15'($urandom_range(120));
            else if (pick < 30) begin
                cx = 16'($urandom);
                cy = 16'($urandom);
                lum = 15'($urandom);
            end else if (pick < 35) cy = 16'($urandom_range(3));
            else if (pick < 40) lum = 15'($urandom_range(32767, 25601));
            send_colour(cx, cy, lum);
            if ($urandom_range(99) < 3) end_burst();
        end
        end_burst();
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_queue.size() == 0) begin
                report_mismatch("output item with no colour outstanding");
            end else begin
                want = pixel_queue.pop_front();
                if (o_red !== want.red)
                    report_mismatch($sformatf("red %h, predicted %h", o_red, want.red));
                if (o_green !== want.green)
                    report_mismatch($sformatf("green %h, predicted %h", o_green, want.green));
                if (o_blue !== want.blue)
                    report_mismatch($sformatf("blue %h, predicted %h", o_blue, want.blue));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("cie_xyy_to_srgb verification failed");
                $finish;
            end
        end
    end

    initial begin
        fill_gamma_lut();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 66;
        test_directed();
        test_random_stream(210);

        send_idle_pct = 66;
        recv_idle_pct = 6;
        test_random_stream(210);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(210);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("cie_xyy_to_srgb verification clean");
        end else begin
            $display("cie_xyy_to_srgb verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cxs_pkg.sv
hw/rtl/cxs_matrix.sv
hw/rtl/cxs_divider.sv
hw/rtl/cxs_encode.sv
hw/rtl/cie_xyy_to_srgb.sv
dv/cie_xyy_to_srgb_tb.sv
